### design/slt_pkg.sv
package slt_pkg;

    // Field widths fixed by the request and result formats
    localparam int unsigned FUNC_W  = 3;
    localparam int unsigned POS_W   = 6;
    localparam int unsigned DATA_W  = 32;

    // Internal length/index width, wide enough for the largest supported capacity
    localparam int unsigned LEN_W   = 11;

    // Operation codes
    localparam logic [FUNC_W-1:0] OP_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] OP_DELETE = 3'd1;
    localparam logic [FUNC_W-1:0] OP_GET    = 3'd2;
    localparam logic [FUNC_W-1:0] OP_LOCATE = 3'd3;
    localparam logic [FUNC_W-1:0] OP_CLEAR  = 3'd4;

    // Broadcast control to every cell of the row
    typedef struct packed {
        logic             ins;   // insert: cells at/after target move up
        logic             del;   // delete: cells at/after target move down
        logic [LEN_W-1:0] tgt;   // 0-based target slot
        logic [LEN_W-1:0] fill;  // current length, qualifies the compare
    } cell_cmd_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

endpackage

### design/slt_cell.sv
module slt_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic                         clk,
    input  slt_pkg::cell_cmd_t           cmd,
    input  logic [slt_pkg::DATA_W-1:0]   key,
    input  logic [slt_pkg::DATA_W-1:0]   left_data,
    input  logic [slt_pkg::DATA_W-1:0]   right_data,
    output logic [slt_pkg::DATA_W-1:0]   data,
    output logic                         match
);

    localparam logic [slt_pkg::LEN_W-1:0] SLOT = slt_pkg::LEN_W'(INDEX);

    logic [slt_pkg::DATA_W-1:0] data_reg;
    logic [slt_pkg::DATA_W-1:0] data_next;

    // Shift/load selection for this slot
    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins)
        begin
            if (SLOT > cmd.tgt)
                data_next = left_data;
            else if (SLOT == cmd.tgt)
                data_next = key;
        end
        else if (cmd.del)
        begin
            if (SLOT >= cmd.tgt)
                data_next = right_data;
        end
    end

    // Entry storage: contents are don't-care until written
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // Compare only live slots
    assign match = (SLOT < cmd.fill) && (data_reg == key);
    assign data  = data_reg;

endmodule

### design/slt_find.sv
module slt_find #(
    parameter int unsigned CAPACITY = 32
) (
    input  logic [CAPACITY-1:0]        hits,
    output logic [slt_pkg::LEN_W-1:0]  first_pos
);

    // Lowest set hit wins; 1-based, zero when none
    always_comb
    begin
        first_pos = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (hits[i])
                first_pos = slt_pkg::LEN_W'(i + 1);
        end
    end

endmodule

### design/sequential_list_table.sv
// Ordered list of signed 32-bit words held in a row of CAPACITY cells, one entry
// per cell. A transaction is taken when start is high and busy is low; busy then
// stays high for one cycle while every cell shifts, loads or compares at once,
// and the result follows with done high for exactly one cycle. A new transaction
// may be started in the cycle that done is high, while the registered result
// that the first-match search resolves is presented; none is taken while the
// cell row executes. Results cannot be held off: the receiver must take each
// one in the cycle done is high. No clearing pass is needed after reset.
module sequential_list_table #(
    parameter int unsigned CAPACITY = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [slt_pkg::FUNC_W-1:0]    func,
    input  logic [slt_pkg::POS_W-1:0]     position,
    input  logic signed [slt_pkg::DATA_W-1:0] value,
    output logic                          done,
    output logic                          failed,
    output logic signed [slt_pkg::DATA_W-1:0] read_value,
    output logic [slt_pkg::POS_W-1:0]     found_position,
    output logic [slt_pkg::POS_W-1:0]     count,
    output logic                          is_empty
);

    localparam int unsigned FILL_W = $clog2(CAPACITY + 1);
    localparam int unsigned IDX_W  = $clog2(CAPACITY);
    localparam logic [slt_pkg::LEN_W-1:0] CAP_LEN = slt_pkg::LEN_W'(CAPACITY);

    // Control state
    slt_pkg::state_t              state_reg;
    slt_pkg::state_t              state_next;
    logic [FILL_W-1:0]            fill_reg;
    logic [FILL_W-1:0]            fill_next;
    logic                         done_reg;

    // Captured transaction
    logic [slt_pkg::FUNC_W-1:0]   op_reg;
    logic [slt_pkg::POS_W-1:0]    pos_reg;
    logic [slt_pkg::DATA_W-1:0]   val_reg;

    // Result registers
    logic                         fail_reg;
    logic                         fail_next;
    logic [slt_pkg::DATA_W-1:0]   rd_reg;
    logic [slt_pkg::DATA_W-1:0]   rd_next;
    logic [CAPACITY-1:0]          hit_reg;

    // Cell row
    logic [slt_pkg::DATA_W-1:0]   cell_data [CAPACITY];
    logic [CAPACITY-1:0]          cell_match;
    slt_pkg::cell_cmd_t           cmd;

    logic                         accept;
    logic                         exec;
    logic [slt_pkg::LEN_W-1:0]    pos_ext;
    logic [slt_pkg::LEN_W-1:0]    fill_ext;
    logic [slt_pkg::LEN_W-1:0]    tgt;
    logic                         ins_ok;
    logic                         rd_ok;
    logic [slt_pkg::LEN_W-1:0]    first_pos;

    assign accept   = start && !busy;
    assign exec     = (state_reg == slt_pkg::ST_EXEC);
    assign busy     = exec;
    assign pos_ext  = slt_pkg::LEN_W'(pos_reg);
    assign fill_ext = slt_pkg::LEN_W'(fill_reg);
    assign tgt      = pos_ext - slt_pkg::LEN_W'(1);

    // Range checks
    assign ins_ok = (op_reg == slt_pkg::OP_INSERT) && (fill_ext < CAP_LEN)
                    && (pos_ext != '0) && (pos_ext <= fill_ext + slt_pkg::LEN_W'(1));
    assign rd_ok  = ((op_reg == slt_pkg::OP_DELETE) || (op_reg == slt_pkg::OP_GET))
                    && (pos_ext != '0) && (pos_ext <= fill_ext);

    // Broadcast to the cells
    always_comb
    begin
        cmd.ins  = exec && ins_ok;
        cmd.del  = exec && rd_ok && (op_reg == slt_pkg::OP_DELETE);
        cmd.tgt  = tgt;
        cmd.fill = fill_ext;
    end

    // Outcome of the transaction in execute
    always_comb
    begin
        fail_next = 1'b0;
        fill_next = fill_reg;
        unique case (op_reg)
            slt_pkg::OP_INSERT:
            begin
                fail_next = !ins_ok;
                if (ins_ok)
                    fill_next = fill_reg + FILL_W'(1);
            end
            slt_pkg::OP_DELETE:
            begin
                fail_next = !rd_ok;
                if (rd_ok)
                    fill_next = fill_reg - FILL_W'(1);
            end
            slt_pkg::OP_GET:    fail_next = !rd_ok;
            slt_pkg::OP_LOCATE: fail_next = 1'b0;
            slt_pkg::OP_CLEAR:  fill_next = '0;
            default:            fail_next = 1'b1;
        endcase
        rd_next = rd_ok ? cell_data[tgt[IDX_W-1:0]] : '0;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            slt_pkg::ST_IDLE: if (accept) state_next = slt_pkg::ST_EXEC;
            slt_pkg::ST_EXEC: state_next = slt_pkg::ST_IDLE;
            default:          state_next = slt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= slt_pkg::ST_IDLE;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= exec;
            if (exec)
                fill_reg <= fill_next;
        end
    end

    // Transaction capture and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= func;
            pos_reg <= position;
            val_reg <= value;
        end
        if (exec)
        begin
            fail_reg <= fail_next;
            rd_reg   <= rd_next;
            hit_reg  <= (op_reg == slt_pkg::OP_LOCATE) ? cell_match : '0;
        end
    end

    // Row of cells, each fed by its neighbours
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [slt_pkg::DATA_W-1:0] left_d;
        logic [slt_pkg::DATA_W-1:0] right_d;

        if (g == 0)
        begin : g_first
            assign left_d = val_reg;
        end
        else
        begin : g_left
            assign left_d = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_d = cell_data[g];
        end
        else
        begin : g_right
            assign right_d = cell_data[g+1];
        end

        slt_cell #(
            .INDEX (g)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .key        (val_reg),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[g]),
            .match      (cell_match[g])
        );
    end

    // First hit of a locate
    slt_find #(
        .CAPACITY (CAPACITY)
    ) u_find (
        .hits      (hit_reg),
        .first_pos (first_pos)
    );

    // Result ports
    assign done           = done_reg;
    assign failed         = fail_reg;
    assign read_value     = rd_reg;
    assign found_position = first_pos[slt_pkg::POS_W-1:0];
    assign count          = slt_pkg::POS_W'(fill_reg);
    assign is_empty       = (fill_reg == '0);

endmodule

### dv/sequential_list_table_tb.sv
`timescale 1ns / 1ps

module sequential_list_table_tb;

    localparam int unsigned LIST_DEPTH   = 32;
    localparam int unsigned RANDOM_ITEMS = 1300;

    // Function codes the block does not decode
    localparam logic [slt_pkg::FUNC_W-1:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [slt_pkg::FUNC_W-1:0] OP_MID_UNUSED   = 3'd6;
    localparam logic [slt_pkg::FUNC_W-1:0] OP_LAST_UNUSED  = 3'd7;

    // Stimulus phases
    localparam int PH_GROW   = 0;
    localparam int PH_SHRINK = 1;
    localparam int PH_MIXED  = 2;

    localparam logic signed [slt_pkg::DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [slt_pkg::DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [slt_pkg::FUNC_W-1:0]        func;
        logic [slt_pkg::POS_W-1:0]         pos;
        logic signed [slt_pkg::DATA_W-1:0] val;
    } list_req_t;

    typedef struct packed {
        logic                              failed;
        logic signed [slt_pkg::DATA_W-1:0] rd;
        logic [slt_pkg::POS_W-1:0]         found;
        logic [slt_pkg::POS_W-1:0]         len;
        logic                              empty;
    } list_rsp_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              start = 1'b0;
    logic [slt_pkg::FUNC_W-1:0]        func = '0;
    logic [slt_pkg::POS_W-1:0]         position = '0;
    logic signed [slt_pkg::DATA_W-1:0] value = '0;
    logic                              busy;
    logic                              done;
    logic                              failed;
    logic signed [slt_pkg::DATA_W-1:0] read_value;
    logic [slt_pkg::POS_W-1:0]         found_position;
    logic [slt_pkg::POS_W-1:0]         count;
    logic                              is_empty;

    list_req_t pending_reqs[$];
    list_rsp_t expected_rsps[$];

    // Shadow of the list contents used for prediction
    logic signed [slt_pkg::DATA_W-1:0] list_words[LIST_DEPTH];
    int unsigned                       list_len = 0;

    int mismatches    = 0;
    int reqs_accepted = 0;
    int rsps_checked  = 0;
    int op_hits[8];
    int refusals      = 0;
    int full_refusals = 0;
    int peak_len      = 0;
    int locate_hits   = 0;

    // Generator view of the length, used to aim positions
    int unsigned                        gen_len = 0;
    logic signed [slt_pkg::DATA_W-1:0]  seen_vals[$];

    sequential_list_table #(
        .CAPACITY(LIST_DEPTH)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .position       (position),
        .value          (value),
        .done           (done),
        .failed         (failed),
        .read_value     (read_value),
        .found_position (found_position),
        .count          (count),
        .is_empty       (is_empty)
    );

    always #6 clk = ~clk;

    initial
    begin
        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string msg);
    begin
        mismatches++;
        $display("%0t ns: mismatch: %s", $time, msg);
    end
    endtask

    // Apply one list request to the shadow list and work out its result
    task automatic apply_list_op(input list_req_t req, output list_rsp_t rsp);
        int k;
        int p;
    begin
        p   = req.pos;
        rsp = '0;
        op_hits[req.func]++;
        case (req.func)
            slt_pkg::OP_INSERT:
            begin
                if (list_len >= LIST_DEPTH || p < 1 || p > list_len + 1)
                begin
                    rsp.failed = 1'b1;
                    if (list_len >= LIST_DEPTH)
                        full_refusals++;
                end
                else
                begin
                    for (k = list_len; k >= p; k--)
                        list_words[k] = list_words[k-1];
                    list_words[p-1] = req.val;
                    list_len++;
                end
            end
            slt_pkg::OP_DELETE:
            begin
                if (p < 1 || p > list_len)
                    rsp.failed = 1'b1;
                else
                begin
                    rsp.rd = list_words[p-1];
                    for (k = p; k < list_len; k++)
                        list_words[k-1] = list_words[k];
                    list_len--;
                end
            end
            slt_pkg::OP_GET:
            begin
                if (p < 1 || p > list_len)
                    rsp.failed = 1'b1;
                else
                    rsp.rd = list_words[p-1];
            end
            slt_pkg::OP_LOCATE:
            begin
                for (k = 0; k < list_len; k++)
                begin
                    if (list_words[k] == req.val)
                    begin
                        rsp.found = slt_pkg::POS_W'(k + 1);
                        locate_hits++;
                        break;
                    end
                end
            end
            slt_pkg::OP_CLEAR:
                list_len = 0;
            default:
                rsp.failed = 1'b1;
        endcase
        if (rsp.failed)
            refusals++;
        if (list_len > peak_len)
            peak_len = list_len;
        rsp.len   = slt_pkg::POS_W'(list_len);
        rsp.empty = (list_len == 0);
    end
    endtask

    // Queue a request, keeping the generator's length in step
    task automatic add_req(input logic [slt_pkg::FUNC_W-1:0] f, input int p,
                           input logic signed [slt_pkg::DATA_W-1:0] v);
        list_req_t req;
    begin
        req.func = f;
        req.pos  = slt_pkg::POS_W'(p);
        req.val  = v;
        pending_reqs.push_back(req);
        case (f)
            slt_pkg::OP_INSERT:
            begin
                if (gen_len < LIST_DEPTH && p >= 1 && p <= gen_len + 1)
                begin
                    gen_len++;
                    seen_vals.push_back(v);
                    if (seen_vals.size() > 16)
                        void'(seen_vals.pop_front());
                end
            end
            slt_pkg::OP_DELETE:
                if (p >= 1 && p <= gen_len)
                    gen_len--;
            slt_pkg::OP_CLEAR:
                gen_len = 0;
            default:
                ;
        endcase
    end
    endtask

    function automatic logic signed [slt_pkg::DATA_W-1:0] edge_word();
    begin
        case ($urandom_range(3))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return '0;
            default: return -1;
        endcase
    end
    endfunction

    // Driver: present the oldest pending request, idling at random
    always @(posedge clk)
    begin : drive
        list_rsp_t rsp;
        bit        taken;
        bit        quiet;
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            taken = start && !busy;
            if (taken)
            begin
                apply_list_op(pending_reqs.pop_front(), rsp);
                expected_rsps.push_back(rsp);
                reqs_accepted++;
            end
            quiet = (reqs_accepted >= 500 && reqs_accepted < 800);
            if (start && !taken)
                ;   // hold the transaction until it is taken
            else if (pending_reqs.size() != 0 && (quiet || $urandom_range(99) >= 25))
            begin
                start    <= 1'b1;
                func     <= pending_reqs[0].func;
                position <= pending_reqs[0].pos;
                value    <= pending_reqs[0].val;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: every strobed result against the oldest expectation
    always @(posedge clk)
    begin : watch
        list_rsp_t want;
        if (rst_n && done)
        begin
            if (expected_rsps.size() == 0)
                report_mismatch("result with no transaction outstanding");
            else
            begin
                want = expected_rsps.pop_front();
                if (failed !== want.failed)
                    report_mismatch($sformatf("result %0d failed %b, want %b",
                                              rsps_checked, failed, want.failed));
                if (read_value !== want.rd)
                    report_mismatch($sformatf("result %0d read_value %h, want %h",
                                              rsps_checked, read_value, want.rd));
                if (found_position !== want.found)
                    report_mismatch($sformatf("result %0d found_position %0d, want %0d",
                                              rsps_checked, found_position, want.found));
                if (count !== want.len)
                    report_mismatch($sformatf("result %0d count %0d, want %0d",
                                              rsps_checked, count, want.len));
                if (is_empty !== want.empty)
                    report_mismatch($sformatf("result %0d is_empty %b, want %b",
                                              rsps_checked, is_empty, want.empty));
                rsps_checked++;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        int i;
        int phase;
        int roll;
        int t_ins;
        int t_del;
        int t_get;
        int t_loc;
        int t_clr;
        int p;
        logic [slt_pkg::FUNC_W-1:0]        f;
        logic signed [slt_pkg::DATA_W-1:0] v;

        foreach (op_hits[j])
            op_hits[j] = 0;

        // Directed: empty list, bad positions, extremes, first match, stale data
        add_req(slt_pkg::OP_GET,    1, 0);
        add_req(slt_pkg::OP_DELETE, 1, 0);
        add_req(slt_pkg::OP_LOCATE, 5, 5);
        add_req(slt_pkg::OP_INSERT, 0, 7);
        add_req(slt_pkg::OP_INSERT, 2, 7);
        add_req(slt_pkg::OP_INSERT, 1, WORD_MIN);
        add_req(slt_pkg::OP_INSERT, 2, WORD_MAX);
        add_req(slt_pkg::OP_INSERT, 2, -1);
        add_req(slt_pkg::OP_INSERT, 1, 0);
        add_req(slt_pkg::OP_GET,    4, 0);
        add_req(slt_pkg::OP_GET,    5, 0);
        add_req(slt_pkg::OP_GET,    63, 0);
        add_req(slt_pkg::OP_LOCATE, 0, -1);
        add_req(slt_pkg::OP_LOCATE, 0, 12345);
        add_req(slt_pkg::OP_INSERT, 6, 1);
        add_req(slt_pkg::OP_DELETE, 2, 0);
        add_req(slt_pkg::OP_DELETE, 0, 0);
        add_req(slt_pkg::OP_DELETE, 3, 0);
        add_req(OP_FIRST_UNUSED,    63, -1);
        add_req(OP_MID_UNUSED,      1, 0);
        add_req(OP_LAST_UNUSED,     63, -1);
        add_req(slt_pkg::OP_INSERT, 1, -1);
        add_req(slt_pkg::OP_LOCATE, 0, -1);
        add_req(slt_pkg::OP_CLEAR,  63, -1);
        add_req(slt_pkg::OP_GET,    1, 0);
        add_req(slt_pkg::OP_LOCATE, 0, 0);

        // Random: phases that fill, drain or churn the list
        phase = PH_GROW;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 80 == 0)
                phase = (i == 0) ? PH_GROW : $urandom_range(2);
            case (phase)
                PH_GROW:
                begin
                    t_ins = 72; t_del = 78; t_get = 86; t_loc = 95; t_clr = 97;
                end
                PH_SHRINK:
                begin
                    t_ins = 20; t_del = 62; t_get = 76; t_loc = 91; t_clr = 95;
                end
                default:
                begin
                    t_ins = 36; t_del = 56; t_get = 72; t_loc = 91; t_clr = 95;
                end
            endcase
            roll = $urandom_range(99);
            if (roll < t_ins)
                f = slt_pkg::OP_INSERT;
            else if (roll < t_del)
                f = slt_pkg::OP_DELETE;
            else if (roll < t_get)
                f = slt_pkg::OP_GET;
            else if (roll < t_loc)
                f = slt_pkg::OP_LOCATE;
            else if (roll < t_clr)
                f = slt_pkg::OP_CLEAR;
            else
                f = slt_pkg::FUNC_W'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));

            // Mostly valid positions, with edges and noise
            if ($urandom_range(99) < 85)
            begin
                if (f == slt_pkg::OP_INSERT)
                begin
                    case ($urandom_range(3))
                        0: p = 1;
                        1: p = gen_len + 1;
                        default: p = $urandom_range(gen_len + 1, 1);
                    endcase
                end
                else if (gen_len == 0)
                    p = $urandom_range(63);
                else
                    p = $urandom_range(gen_len, 1);
            end
            else
            begin
                case ($urandom_range(3))
                    0: p = 0;
                    1: p = gen_len + 1;
                    2: p = gen_len + 2;
                    default: p = $urandom_range(63);
                endcase
            end

            // Values: repeats keep locate interesting
            roll = $urandom_range(99);
            if (f == slt_pkg::OP_INSERT)
            begin
                if (roll < 45)
                    v = $urandom;
                else if (roll < 75)
                    v = $urandom_range(15);
                else if (roll < 90 && seen_vals.size() != 0)
                    v = seen_vals[$urandom_range(seen_vals.size() - 1)];
                else
                    v = edge_word();
            end
            else if (f == slt_pkg::OP_LOCATE && roll < 60 && seen_vals.size() != 0)
                v = seen_vals[$urandom_range(seen_vals.size() - 1)];
            else if (f == slt_pkg::OP_LOCATE && roll < 75)
                v = $urandom_range(15);
            else
                v = $urandom;
            add_req(f, p, v);
        end

        @(posedge rst_n);
        while (pending_reqs.size() != 0)
            @(posedge clk);
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Checked %0d of %0d transactions: %0d insert, %0d delete, %0d get, %0d clear",
                 rsps_checked, reqs_accepted, op_hits[slt_pkg::OP_INSERT],
                 op_hits[slt_pkg::OP_DELETE], op_hits[slt_pkg::OP_GET],
                 op_hits[slt_pkg::OP_CLEAR]);
        $display("%0d locate (%0d found), %0d unused code, %0d refused (%0d full), peak %0d",
                 op_hits[slt_pkg::OP_LOCATE], locate_hits,
                 op_hits[OP_FIRST_UNUSED] + op_hits[OP_MID_UNUSED] + op_hits[OP_LAST_UNUSED],
                 refusals, full_refusals, peak_len);
        if (mismatches == 0)
            $display("** sequential_list_table: PASSED **");
        else
            $display("** sequential_list_table: FAILED **");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Timed out with %0d transactions pending and %0d results outstanding",
                 pending_reqs.size(), expected_rsps.size());
        $display("** sequential_list_table: FAILED **");
        $finish;
    end

endmodule

### sim.f
design/slt_pkg.sv
design/slt_cell.sv
design/slt_find.sv
design/sequential_list_table.sv
dv/sequential_list_table_tb.sv
